// ===== sv/sorted_array_list_macros.svh =====
// Assertion macros for the sorted array list.
`ifndef SORTED_ARRAY_LIST_MACROS_SVH
`define SORTED_ARRAY_LIST_MACROS_SVH

`ifndef SYNTHESIS

`define SAL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted_array_list: property failed");

`define SAL_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sorted_array_list: forbidden condition seen");

`else

`define SAL_ASSERT(label, prop)

`define SAL_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== sv/sal_pkg.sv =====
// Package: sizes, command and status codes, and memory request type.
`default_nettype none

package sal_pkg;

    localparam int CAPACITY    = 128;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 8;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [VALUE_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== sv/sal_if.sv =====
// Command and response channel interfaces.
`default_nettype none

interface sal_cmd_if
    import sal_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sal_rsp_if
    import sal_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic                   found;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_full;
    logic                   is_empty;

    modport source (output valid, output status, output found, output entry_count,
                    output is_full, output is_empty, input ready);
    modport sink   (input valid, input status, input found, input entry_count,
                    input is_full, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== sv/sal_mem.sv =====
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module sal_mem
    import sal_pkg::*;
(
    input  wire logic               clk,
    input  wire mem_req_t           req,
    output      logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/sorted_array_list.sv =====
// Sorted array list: keeps up to CAPACITY signed 32-bit words in ascending order in one
// synchronous memory. Insert, delete and lookup scan the entries one per cycle on the
// single read port; insert and delete shift entries on the fly through the write port
// behind the read. An insert into a full list still scans, as a lookup, to report found;
// clear skips the scan. A new command is accepted in the cycle after its response is
// loaded, even if that response has not been taken yet. No clearing pass is needed after
// reset.
`default_nettype none
`include "sorted_array_list_macros.svh"

module sorted_array_list
    import sal_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    sal_cmd_if.sink  cmd,
    sal_rsp_if.source rsp
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t                    state_reg,    state_next;
    logic [1:0]                kind_reg,     kind_next;
    logic signed [VALUE_W-1:0] value_reg,    value_next;
    logic [CNT_W-1:0]          count_reg,    count_next;
    logic [CNT_W-1:0]          idx_reg,      idx_next;
    logic                      rvld_reg,     rvld_next;
    logic [ADDR_W-1:0]         paddr_reg,    paddr_next;
    logic                      found_reg,    found_next;
    logic                      ins_done_reg, ins_done_next;
    logic [VALUE_W-1:0]        carry_reg,    carry_next;
    logic [1:0]                status_reg,   status_next;

    logic                   out_valid_reg,  out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic                   out_found_reg,  out_found_next;
    logic [COUNT_OUT_W-1:0] out_count_reg,  out_count_next;
    logic                   out_full_reg,   out_full_next;
    logic                   out_empty_reg,  out_empty_next;

    mem_req_t           mem_req;
    logic [VALUE_W-1:0] rdata;
    logic               eq;
    logic               gt;

    sal_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.is_full     = out_full_reg;
    assign rsp.is_empty    = out_empty_reg;

    assign eq = ($signed(rdata) == value_reg);
    assign gt = ($signed(rdata) >  value_reg);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rvld_next       = 1'b0;
        paddr_next      = paddr_reg;
        found_next      = found_reg;
        ins_done_next   = ins_done_reg;
        carry_next      = carry_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        out_full_next   = out_full_reg;
        out_empty_next  = out_empty_reg;
        mem_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next     = cmd.kind;
                    value_next    = cmd.value;
                    found_next    = 1'b0;
                    ins_done_next = 1'b0;
                    status_next   = STATUS_DONE;
                    idx_next      = '0;
                    if (cmd.kind == KIND_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (cmd.kind == KIND_INSERT && count_reg == CNT_W'(CAPACITY))
                    begin
                        // no room: scan as a lookup so found still reports membership
                        kind_next   = KIND_LOOKUP;
                        status_next = STATUS_FULL;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue the next read while entries remain
                if (idx_reg != count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                    rvld_next     = 1'b1;
                    paddr_next    = idx_reg[ADDR_W-1:0];
                end

                // process the word read in the previous cycle
                if (rvld_reg)
                begin
                    if (eq)
                    begin
                        found_next = 1'b1;
                    end
                    case (kind_reg)
                        KIND_INSERT:
                        begin
                            if (ins_done_reg)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = paddr_reg;
                                mem_req.wdata = carry_reg;
                                carry_next    = rdata;
                            end
                            else if (gt)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = paddr_reg;
                                mem_req.wdata = value_reg;
                                carry_next    = rdata;
                                ins_done_next = 1'b1;
                            end
                        end
                        KIND_DELETE:
                        begin
                            // close the gap left by the first match
                            if (found_reg)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = paddr_reg - ADDR_W'(1);
                                mem_req.wdata = rdata;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // all entries read and processed: finish the command
                if (idx_reg == count_reg && !rvld_reg)
                begin
                    state_next = ST_DONE;
                    case (kind_reg)
                        KIND_INSERT:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = count_reg[ADDR_W-1:0];
                            mem_req.wdata = ins_done_reg ? carry_reg : value_reg;
                            count_next    = count_reg + CNT_W'(1);
                        end
                        KIND_DELETE:
                        begin
                            if (found_reg)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = STATUS_ABSENT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = found_reg;
                    out_count_next  = COUNT_OUT_W'(count_reg);
                    out_full_next   = (count_reg == CNT_W'(CAPACITY));
                    out_empty_next  = (count_reg == '0);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rvld_reg      <= rvld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        paddr_reg      <= paddr_next;
        found_reg      <= found_next;
        ins_done_reg   <= ins_done_next;
        carry_reg      <= carry_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
        out_full_reg   <= out_full_next;
        out_empty_reg  <= out_empty_next;
    end

    `SAL_ASSERT(a_accept_leaves_idle, (cmd.valid && cmd.ready) |=> (state_reg != ST_IDLE))
    `SAL_ASSERT(a_count_in_range, count_reg <= CNT_W'(CAPACITY))
    `SAL_ASSERT_NEVER(a_write_outside_scan, mem_req.we && (state_reg != ST_SCAN))
    `SAL_ASSERT(a_insert_scan_has_room, (state_reg == ST_SCAN && kind_reg == KIND_INSERT) |-> (count_reg < CNT_W'(CAPACITY)))

endmodule

`default_nettype wire
